// File: src/cccv_pkg.sv
// Package: shared types, codes and constants of the CC/CV charge controller.
`default_nettype none

package cccv_pkg;

  // Default build constants
  localparam int unsigned DUTY_MAX   = 2399;
  localparam int unsigned CELL_COUNT = 3;

  // Minimum internal duty width (width of the duty result field)
  localparam int unsigned DUTY_OUT_W = 12;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_CAP   = 3'd0,
    CFG_PRECHARGE     = 3'd1,
    CFG_RECHARGE      = 3'd2,
    CFG_TOLERANCE     = 3'd3,
    CFG_DUTY_STEP     = 3'd4,
    CFG_START_DUTY    = 3'd5,
    CFG_TAPER         = 3'd6,
    CFG_CUTOFF        = 3'd7
  } cfg_idx_e;

  // Charge state, one-hot internally
  typedef enum logic [5:0] {
    M_FAULT = 6'b000001,
    M_PRE   = 6'b000010,
    M_CC    = 6'b000100,
    M_CV    = 6'b001000,
    M_DONE  = 6'b010000,
    M_RECH  = 6'b100000
  } mode_e;

  // Charge state codes as seen on the result word
  localparam logic [2:0] ST_FAULT = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_CC    = 3'd2;
  localparam logic [2:0] ST_CV    = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_RECH  = 3'd5;

  typedef enum logic [1:0] {
    FLT_NO_SRC = 2'd0,
    FLT_UNDER  = 2'd1,
    FLT_OVER   = 2'd2
  } fault_e;

  typedef struct packed {
    logic [12:0] current_cap_ma;
    logic [12:0] precharge_current_ma;
    logic [12:0] recharge_current_ma;
    logic [9:0]  current_tolerance_ma;
    logic [7:0]  duty_step;
    logic [11:0] start_duty;
    logic [12:0] taper_current_ma;
    logic [12:0] cutoff_current_ma;
  } cfg_t;

  typedef struct packed {
    logic [13:0] battery_mv;
    logic [15:0] charge_ma;
    logic        source_present;
    logic [12:0] negotiated_ma;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    fault_e      fault;
    logic        running;
    logic [13:0] prior_mv;
    logic [6:0]  percent;
    logic        slow;
  } state_t;

  typedef struct packed {
    logic [2:0]  charge_state;
    logic [1:0]  fault_kind;
    logic [11:0] duty_value;
    logic        charger_on;
    logic [6:0]  charge_percent;
    logic        slow_tick;
  } result_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      M_FAULT: code = ST_FAULT;
      M_PRE:   code = ST_PRE;
      M_CC:    code = ST_CC;
      M_CV:    code = ST_CV;
      M_DONE:  code = ST_DONE;
      M_RECH:  code = ST_RECH;
      default: code = ST_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/cccv_in_if.sv
// Interface: tick word channel (sensed voltage, current, source, contract).
`default_nettype none

interface cccv_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] battery_mv;
  logic [15:0] charge_ma;
  logic        source_present;
  logic [12:0] negotiated_ma;

  modport source (
    output valid, battery_mv, charge_ma, source_present, negotiated_ma,
    input  ready
  );

  modport sink (
    input  valid, battery_mv, charge_ma, source_present, negotiated_ma,
    output ready
  );
endinterface

`default_nettype wire

// File: src/cccv_out_if.sv
// Interface: result word channel (charge state, fault, duty, status).
`default_nettype none

interface cccv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  charge_state;
  logic [1:0]  fault_kind;
  logic [11:0] duty_value;
  logic        charger_on;
  logic [6:0]  charge_percent;
  logic        slow_tick;

  modport source (
    output valid, charge_state, fault_kind, duty_value, charger_on,
           charge_percent, slow_tick,
    input  ready
  );

  modport sink (
    input  valid, charge_state, fault_kind, duty_value, charger_on,
           charge_percent, slow_tick,
    output ready
  );
endinterface

`default_nettype wire

// File: src/cccv_battery_charge_controller.sv
// Top level: CC/CV lithium charge controller with tick and result channels.
//
// Usage notes
// - item_i carries one control tick per word: battery_mv, charge_ma,
//   source_present, negotiated_ma. result_o returns one word per tick:
//   charge_state, fault_kind, duty_value, charger_on, charge_percent,
//   slow_tick. Both use valid/ready; a word moves when both are high.
// - A tick accepted on item_i is captured in the input register, then
//   evaluated and stored in the result register that drives result_o.
// - Throughput: one tick per cycle while result_o is not held off. The charge
//   state, duty and SoC registers update in the same cycle the tick leaves the
//   input register, so the next tick sees them right away.
// - Stall: if result_o is held off, the result register keeps its word and
//   one more tick can wait in the input register; item_i.ready then drops.
// - Reset (rst_ni low, async): state fault/no source, duty 0, charger off,
//   SoC 0, fast loop; configuration registers return to their defaults.
// - Configuration: write cfg_we_i/cfg_idx_i/cfg_data_i only while idle.
// - DutyMax sets the duty clamp and, when it needs more than 12 bits, its
//   register width; CellCount scales every pack voltage threshold.
`default_nettype none

module cccv_battery_charge_controller #(
  parameter int unsigned DutyMax   = cccv_pkg::DUTY_MAX,
  parameter int unsigned CellCount = cccv_pkg::CELL_COUNT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  cccv_in_if.sink                              item_i,
  cccv_out_if.source                           result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [cccv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cccv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DutyBits = $clog2(DutyMax + 1);
  localparam int unsigned DutyW    = (DutyBits > cccv_pkg::DUTY_OUT_W) ?
                                     DutyBits : cccv_pkg::DUTY_OUT_W;

  cccv_pkg::cfg_t    cfg;
  cccv_pkg::item_t   item_q;
  logic              in_vld_q, in_vld_d;
  logic              out_vld_q, out_vld_d;
  logic              take_in, advance;
  cccv_pkg::state_t  st_q, st_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  cccv_pkg::result_t res_q;

  cccv_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: input register frees when its word moves to the result reg
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || advance;
  assign take_in      = item_i.valid && item_i.ready;
  assign in_vld_d     = take_in || (in_vld_q && !advance);
  assign out_vld_d    = advance || (out_vld_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.battery_mv     <= item_i.battery_mv;
      item_q.charge_ma      <= item_i.charge_ma;
      item_q.source_present <= item_i.source_present;
      item_q.negotiated_ma  <= item_i.negotiated_ma;
    end
  end

  cccv_step #(
    .DutyMax   (DutyMax),
    .CellCount (CellCount),
    .DutyW     (DutyW)
  ) u_step (
    .cfg_i  (cfg),
    .item_i (item_q),
    .st_i   (st_q),
    .duty_i (duty_q),
    .st_o   (st_d),
    .duty_o (duty_d)
  );

  // Controller state, updated once per evaluated tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= cccv_pkg::M_FAULT;
      st_q.fault    <= cccv_pkg::FLT_NO_SRC;
      st_q.running  <= 1'b0;
      st_q.prior_mv <= '0;
      st_q.percent  <= '0;
      st_q.slow     <= 1'b0;
      duty_q        <= '0;
    end else if (advance) begin
      st_q   <= st_d;
      duty_q <= duty_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.charge_state   <= cccv_pkg::mode_code(st_d.mode);
      res_q.fault_kind     <= st_d.fault;
      res_q.duty_value     <= duty_d[cccv_pkg::DUTY_OUT_W-1:0];
      res_q.charger_on     <= st_d.running;
      res_q.charge_percent <= st_d.percent;
      res_q.slow_tick      <= st_d.slow;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.charge_state   = res_q.charge_state;
  assign result_o.fault_kind     = res_q.fault_kind;
  assign result_o.duty_value     = res_q.duty_value;
  assign result_o.charger_on     = res_q.charger_on;
  assign result_o.charge_percent = res_q.charge_percent;
  assign result_o.slow_tick      = res_q.slow_tick;

endmodule

`default_nettype wire

// File: src/cccv_cfg_regs.sv
// Configuration register file of the charge controller.
`default_nettype none

module cccv_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cccv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cccv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output cccv_pkg::cfg_t                          cfg_o
);

  cccv_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cccv_pkg::cfg_idx_e'(cfg_idx_i))
        cccv_pkg::CFG_CURRENT_CAP: cfg_d.current_cap_ma       = cfg_data_i[12:0];
        cccv_pkg::CFG_PRECHARGE:   cfg_d.precharge_current_ma = cfg_data_i[12:0];
        cccv_pkg::CFG_RECHARGE:    cfg_d.recharge_current_ma  = cfg_data_i[12:0];
        cccv_pkg::CFG_TOLERANCE:   cfg_d.current_tolerance_ma = cfg_data_i[9:0];
        cccv_pkg::CFG_DUTY_STEP:   cfg_d.duty_step            = cfg_data_i[7:0];
        cccv_pkg::CFG_START_DUTY:  cfg_d.start_duty           = cfg_data_i[11:0];
        cccv_pkg::CFG_TAPER:       cfg_d.taper_current_ma     = cfg_data_i[12:0];
        cccv_pkg::CFG_CUTOFF:      cfg_d.cutoff_current_ma    = cfg_data_i[12:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_cap_ma       <= 13'd1500;
      cfg_q.precharge_current_ma <= 13'd200;
      cfg_q.recharge_current_ma  <= 13'd500;
      cfg_q.current_tolerance_ma <= 10'd50;
      cfg_q.duty_step            <= 8'd3;
      cfg_q.start_duty           <= 12'd850;
      cfg_q.taper_current_ma     <= 13'd200;
      cfg_q.cutoff_current_ma    <= 13'd150;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/cccv_step.sv
// Next-state logic for one control tick: state decision, SoC and duty loop.
`default_nettype none

module cccv_step #(
  parameter int unsigned DutyMax   = cccv_pkg::DUTY_MAX,
  parameter int unsigned CellCount = cccv_pkg::CELL_COUNT,
  parameter int unsigned DutyW     = cccv_pkg::DUTY_OUT_W
) (
  input  wire cccv_pkg::cfg_t     cfg_i,
  input  wire cccv_pkg::item_t    item_i,
  input  wire cccv_pkg::state_t   st_i,
  input  wire logic [DutyW-1:0]   duty_i,
  output cccv_pkg::state_t        st_o,
  output logic [DutyW-1:0]        duty_o
);

  // Pack voltage thresholds
  localparam logic [15:0] VMin    = 16'(CellCount * 2600);
  localparam logic [15:0] VMax    = 16'(CellCount * 4200);
  localparam logic [15:0] VRech   = 16'(CellCount * 4050);
  localparam logic [15:0] VCcMin  = 16'(CellCount * 3000);
  localparam logic [15:0] VCv     = 16'(CellCount * 4100);
  localparam logic [15:0] VBad    = 16'(CellCount * 4620);
  localparam logic [15:0] VCcLo   = 16'(CellCount * 3000 + 50);
  localparam logic [15:0] VCcHi   = 16'(CellCount * 4100 - 50);
  localparam logic [15:0] VFull   = 16'(CellCount * 4200 - 25);
  localparam logic [15:0] VRechLo = VRech - 16'd75;
  // SoC = (v - VMin) * 100 / (1600 * cells) = ((v - VMin) >> 4) / cells
  localparam logic [11:0] Recip   = 12'((2048 + CellCount - 1) / CellCount);
  localparam logic [DutyW:0] DutyCap = (DutyW + 1)'(DutyMax);

  logic [15:0]      v16, vin16, pv16;
  logic [15:0]      dlt;
  logic [8:0]       quo;
  logic [20:0]      prod;
  logic [6:0]       soc;
  cccv_pkg::mode_e  m;
  cccv_pkg::fault_e f;
  logic             run, slow;
  logic [13:0]      pv;
  logic [DutyW-1:0] d1;
  logic [DutyW:0]   dw, dsum, sub1, sub2;
  logic [DutyW-1:0] amt1, amt2;
  logic [12:0]      maxc;
  logic [16:0]      chg17, tol17, tgt17, rch17;
  logic             lo_a, hi_a, lo_r, hi_r, below_cut;

  assign v16   = {2'b00, st_i.prior_mv};
  assign vin16 = {2'b00, item_i.battery_mv};
  assign dlt   = v16 - VMin;
  assign quo   = dlt[12:4];
  assign prod  = quo * Recip;
  assign chg17 = {1'b0, item_i.charge_ma};
  assign tol17 = {7'd0, cfg_i.current_tolerance_ma};
  assign rch17 = {4'd0, cfg_i.recharge_current_ma};
  assign amt1  = DutyW'(cfg_i.duty_step);
  assign amt2  = DutyW'({cfg_i.duty_step, 1'b0});

  always_comb begin
    m    = st_i.mode;
    f    = st_i.fault;
    run  = st_i.running;
    slow = st_i.slow;
    d1   = duty_i;

    // State of charge from the previous voltage, never falling
    if (v16 <= VMin) begin
      soc = '0;
    end else if (v16 > VMax) begin
      soc = cccv_pkg::PCT_FULL;
    end else begin
      soc = prod[17:11];
    end
    if (m == cccv_pkg::M_DONE) begin
      soc = cccv_pkg::PCT_FULL;
    end

    // Charge state decision from the previous voltage
    if (item_i.source_present) begin
      priority if (v16 > VMin && v16 < VCcMin) begin
        m = cccv_pkg::M_PRE;
      end else if (v16 >= VCcLo && v16 < VCcHi && m != cccv_pkg::M_DONE) begin
        if (m != cccv_pkg::M_CC) slow = 1'b0;
        m = cccv_pkg::M_CC;
      end else if (m != cccv_pkg::M_DONE && v16 >= VCv &&
                   item_i.charge_ma > {3'd0, cfg_i.taper_current_ma}) begin
        if (m != cccv_pkg::M_CV) slow = 1'b1;
        m = cccv_pkg::M_CV;
      end else if (v16 >= VFull &&
                   item_i.charge_ma <= {3'd0, cfg_i.taper_current_ma}) begin
        slow = 1'b1;
        m    = cccv_pkg::M_DONE;
      end else if (m == cccv_pkg::M_DONE && v16 <= VRechLo) begin
        slow = 1'b1;
        m    = cccv_pkg::M_RECH;
      end else if (v16 < VMin) begin
        m = cccv_pkg::M_FAULT;
        f = cccv_pkg::FLT_UNDER;
      end else if (v16 > VMax) begin
        m = cccv_pkg::M_FAULT;
        f = cccv_pkg::FLT_OVER;
      end else begin
        m = m;  // boundary voltage: hold
      end
    end else begin
      m = cccv_pkg::M_FAULT;
      f = cccv_pkg::FLT_NO_SRC;
    end

    // Power stage enable
    if (m == cccv_pkg::M_FAULT || m == cccv_pkg::M_DONE) begin
      run = 1'b0;
      d1  = '0;
    end else if (!run) begin
      run = 1'b1;
      d1  = DutyW'(cfg_i.start_duty);
    end

    // Implausible reading stored as zero
    pv   = (vin16 > VBad) ? 14'd0 : item_i.battery_mv;
    pv16 = {2'b00, pv};

    // Current reference loop
    maxc = (item_i.negotiated_ma > cfg_i.current_cap_ma) ?
           cfg_i.current_cap_ma : item_i.negotiated_ma;
    if (m == cccv_pkg::M_PRE) maxc = cfg_i.precharge_current_ma;
    tgt17 = {4'd0, maxc};
    // Band edges as chg + tol < tgt and chg > tgt + tol: no sign needed
    lo_a = (chg17 + tol17) < tgt17;
    hi_a = chg17 > (tgt17 + tol17);
    lo_r = (chg17 + tol17) < rch17;
    hi_r = chg17 > (rch17 + tol17);
    below_cut = item_i.charge_ma < {3'd0, cfg_i.cutoff_current_ma};

    dsum = {1'b0, d1} + (DutyW + 1)'(cfg_i.duty_step);
    sub1 = (d1 > amt1) ? {1'b0, d1 - amt1} : '0;
    sub2 = (d1 > amt2) ? {1'b0, d1 - amt2} : '0;
    dw   = {1'b0, d1};

    priority if (m == cccv_pkg::M_CC || m == cccv_pkg::M_PRE ||
                 (m == cccv_pkg::M_CV && below_cut)) begin
      if (lo_a) dw = dsum;
      else if (hi_a) dw = sub1;
    end else if (m == cccv_pkg::M_CV) begin
      if (pv16 >= VFull) dw = sub2;
    end else if (m == cccv_pkg::M_RECH) begin
      if (lo_r) dw = dsum;
      else if (hi_r) dw = sub2;
      else m = cccv_pkg::M_CV;
    end else begin
      dw = '0;
    end

    duty_o = (dw > DutyCap) ? DutyCap[DutyW-1:0] : dw[DutyW-1:0];

    st_o.mode     = m;
    st_o.fault    = f;
    st_o.running  = run;
    st_o.prior_mv = pv;
    st_o.percent  = (soc > st_i.percent) ? soc : st_i.percent;
    st_o.slow     = slow;
  end

endmodule

`default_nettype wire
